// ===== src/pacl_pkg.sv =====
// ----------------------------------------------------------------------------
// pacl_pkg
// Shared types and constants of the per-address connection limiter.
// ----------------------------------------------------------------------------
package pacl_pkg;

    localparam int TABLE_ENTRIES_DEFAULT = 64;
    localparam int COUNT_BITS_DEFAULT    = 8;

    localparam int          MAX_BITS      = 8;
    localparam int          ADDRESS_BITS  = 32;
    localparam int          LIVE_BITS     = 8;
    localparam logic [7:0]  MAX_RESET     = 8'd2;

    // result status codes
    typedef enum logic [1:0] {
        ST_OK         = 2'd0,
        ST_OVER_LIMIT = 2'd1,
        ST_TABLE_FULL = 2'd2,
        ST_UNKNOWN    = 2'd3
    } status_t;

    // request kinds
    typedef enum logic {
        REQ_CONNECT    = 1'b0,
        REQ_DISCONNECT = 1'b1
    } req_t;

    // controller states
    typedef enum logic [1:0] {
        S_CLEAR,
        S_IDLE,
        S_SCAN,
        S_RESOLVE
    } state_t;

endpackage

// ===== src/per_address_connection_limiter_unit.sv =====
// ----------------------------------------------------------------------------
// per_address_connection_limiter_unit
// Live connection count per IPv4 source address with a configurable limit.
// ----------------------------------------------------------------------------
// Operation: after the accept cycle the table is scanned until the address
//   is found or the last slot is read; then done pulses with the result.
// One beat at a time; the table is scanned one slot per cycle
//   through the single read port.
// Reset: a clearing pass over every slot runs with busy high;
//   max_per_address resets to 2. Results cannot be stalled by the receiver.
module per_address_connection_limiter_unit #(
    parameter int TABLE_ENTRIES = pacl_pkg::TABLE_ENTRIES_DEFAULT,
    parameter int COUNT_BITS    = pacl_pkg::COUNT_BITS_DEFAULT
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              start,
    output logic                              busy,
    input  logic                              req_type,
    input  logic [pacl_pkg::ADDRESS_BITS-1:0] source_address,
    output logic                              done,
    output logic                              allowed,
    output logic [1:0]                        status,
    output logic [pacl_pkg::LIVE_BITS-1:0]    live_count,
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [pacl_pkg::MAX_BITS-1:0]     cfg_data
);

    localparam int IDX_BITS = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;

    logic [pacl_pkg::MAX_BITS-1:0]     max_reg;
    logic                              wr_en;
    logic [IDX_BITS-1:0]               wr_addr;
    logic                              wr_valid;
    logic [pacl_pkg::ADDRESS_BITS-1:0] wr_key;
    logic [COUNT_BITS-1:0]             wr_count;
    logic                              rd_en;
    logic [IDX_BITS-1:0]               rd_addr;
    logic                              rd_valid;
    logic [pacl_pkg::ADDRESS_BITS-1:0] rd_key;
    logic [COUNT_BITS-1:0]             rd_count;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            max_reg <= pacl_pkg::MAX_RESET;
        else if (cfg_valid && cfg_ready)
            max_reg <= cfg_data;
    end

    pacl_ctrl #(
        .TABLE_ENTRIES (TABLE_ENTRIES),
        .COUNT_BITS    (COUNT_BITS),
        .IDX_BITS      (IDX_BITS)
    ) u_ctrl (
        .clk             (clk),
        .rst_n           (rst_n),
        .start           (start),
        .busy            (busy),
        .req_type        (req_type),
        .source_address  (source_address),
        .max_per_address (max_reg),
        .done            (done),
        .allowed         (allowed),
        .status          (status),
        .live_count      (live_count),
        .wr_en           (wr_en),
        .wr_addr         (wr_addr),
        .wr_valid        (wr_valid),
        .wr_key          (wr_key),
        .wr_count        (wr_count),
        .rd_en           (rd_en),
        .rd_addr         (rd_addr),
        .rd_valid        (rd_valid),
        .rd_key          (rd_key),
        .rd_count        (rd_count)
    );

    pacl_table #(
        .TABLE_ENTRIES (TABLE_ENTRIES),
        .COUNT_BITS    (COUNT_BITS),
        .IDX_BITS      (IDX_BITS)
    ) u_table (
        .clk      (clk),
        .wr_en    (wr_en),
        .wr_addr  (wr_addr),
        .wr_valid (wr_valid),
        .wr_key   (wr_key),
        .wr_count (wr_count),
        .rd_en    (rd_en),
        .rd_addr  (rd_addr),
        .rd_valid (rd_valid),
        .rd_key   (rd_key),
        .rd_count (rd_count)
    );

endmodule

// ===== src/pacl_table.sv =====
// ----------------------------------------------------------------------------
// pacl_table
// Address table memory: valid flag, source address and live count per slot,
// one write port and one registered read port.
// ----------------------------------------------------------------------------
module pacl_table #(
    parameter int TABLE_ENTRIES = pacl_pkg::TABLE_ENTRIES_DEFAULT,
    parameter int COUNT_BITS    = pacl_pkg::COUNT_BITS_DEFAULT,
    parameter int IDX_BITS      = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1
) (
    input  logic                              clk,
    input  logic                              wr_en,
    input  logic [IDX_BITS-1:0]               wr_addr,
    input  logic                              wr_valid,
    input  logic [pacl_pkg::ADDRESS_BITS-1:0] wr_key,
    input  logic [COUNT_BITS-1:0]             wr_count,
    input  logic                              rd_en,
    input  logic [IDX_BITS-1:0]               rd_addr,
    output logic                              rd_valid,
    output logic [pacl_pkg::ADDRESS_BITS-1:0] rd_key,
    output logic [COUNT_BITS-1:0]             rd_count
);

    logic                              mem_valid [TABLE_ENTRIES];
    logic [pacl_pkg::ADDRESS_BITS-1:0] mem_key   [TABLE_ENTRIES];
    logic [COUNT_BITS-1:0]             mem_count [TABLE_ENTRIES];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem_valid[wr_addr] <= wr_valid;
            mem_key[wr_addr]   <= wr_key;
            mem_count[wr_addr] <= wr_count;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_valid <= mem_valid[rd_addr];
            rd_key   <= mem_key[rd_addr];
            rd_count <= mem_count[rd_addr];
        end
    end

endmodule

// ===== src/pacl_ctrl.sv =====
// ----------------------------------------------------------------------------
// pacl_ctrl
// Sequencer: clears the table after reset, scans it slot by slot for the
// request's address and a free slot, then decides; an admit writes it back.
// ----------------------------------------------------------------------------
module pacl_ctrl #(
    parameter int TABLE_ENTRIES = pacl_pkg::TABLE_ENTRIES_DEFAULT,
    parameter int COUNT_BITS    = pacl_pkg::COUNT_BITS_DEFAULT,
    parameter int IDX_BITS      = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              start,
    output logic                              busy,
    input  logic                              req_type,
    input  logic [pacl_pkg::ADDRESS_BITS-1:0] source_address,
    input  logic [pacl_pkg::MAX_BITS-1:0]     max_per_address,
    output logic                              done,
    output logic                              allowed,
    output logic [1:0]                        status,
    output logic [pacl_pkg::LIVE_BITS-1:0]    live_count,
    output logic                              wr_en,
    output logic [IDX_BITS-1:0]               wr_addr,
    output logic                              wr_valid,
    output logic [pacl_pkg::ADDRESS_BITS-1:0] wr_key,
    output logic [COUNT_BITS-1:0]             wr_count,
    output logic                              rd_en,
    output logic [IDX_BITS-1:0]               rd_addr,
    input  logic                              rd_valid,
    input  logic [pacl_pkg::ADDRESS_BITS-1:0] rd_key,
    input  logic [COUNT_BITS-1:0]             rd_count
);

    localparam int CMP_BITS = (COUNT_BITS > pacl_pkg::MAX_BITS) ? COUNT_BITS
                                                                 : pacl_pkg::MAX_BITS;
    localparam logic [IDX_BITS-1:0] LAST_IDX = IDX_BITS'(TABLE_ENTRIES - 1);

    pacl_pkg::state_t                  state_reg, state_next;
    logic [IDX_BITS-1:0]               idx_reg, idx_next;
    logic                              req_reg, req_next;
    logic [pacl_pkg::ADDRESS_BITS-1:0] addr_reg, addr_next;
    logic                              match_reg, match_next;
    logic                              free_reg, free_next;
    logic [IDX_BITS-1:0]               slot_reg, slot_next;
    logic [COUNT_BITS-1:0]             count_reg, count_next;
    logic                              done_reg, done_next;
    logic                              allowed_reg, allowed_next;
    pacl_pkg::status_t                 status_reg, status_next;
    logic [pacl_pkg::LIVE_BITS-1:0]    live_reg, live_next;

    logic                              hit;
    logic [COUNT_BITS-1:0]             new_count;
    logic [CMP_BITS-1:0]               count_cmp;
    logic [CMP_BITS-1:0]               max_cmp;

    assign hit       = rd_valid && (rd_key == addr_reg);
    assign count_cmp = CMP_BITS'(count_reg);
    assign max_cmp   = CMP_BITS'(max_per_address);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= pacl_pkg::S_CLEAR;
            idx_reg   <= '0;
            match_reg <= 1'b0;
            free_reg  <= 1'b0;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            idx_reg   <= idx_next;
            match_reg <= match_next;
            free_reg  <= free_next;
            done_reg  <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        req_reg     <= req_next;
        addr_reg    <= addr_next;
        slot_reg    <= slot_next;
        count_reg   <= count_next;
        allowed_reg <= allowed_next;
        status_reg  <= status_next;
        live_reg    <= live_next;
    end

    always_comb
    begin
        state_next   = state_reg;
        idx_next     = idx_reg;
        req_next     = req_reg;
        addr_next    = addr_reg;
        match_next   = match_reg;
        free_next    = free_reg;
        slot_next    = slot_reg;
        count_next   = count_reg;
        done_next    = 1'b0;
        allowed_next = allowed_reg;
        status_next  = status_reg;
        live_next    = live_reg;
        new_count    = count_reg;
        wr_en        = 1'b0;
        wr_addr      = idx_reg;
        wr_valid     = 1'b0;
        wr_key       = addr_reg;
        wr_count     = '0;
        rd_en        = 1'b0;
        rd_addr      = '0;

        unique case (state_reg)
            pacl_pkg::S_CLEAR:
            begin
                wr_en    = 1'b1;
                idx_next = idx_reg + 1'b1;
                if (idx_reg == LAST_IDX)
                begin
                    idx_next   = '0;
                    state_next = pacl_pkg::S_IDLE;
                end
            end

            pacl_pkg::S_IDLE:
            begin
                if (start)
                begin
                    // fetch slot 0 in the accept cycle
                    rd_en      = 1'b1;
                    rd_addr    = '0;
                    idx_next   = '0;
                    req_next   = req_type;
                    addr_next  = source_address;
                    match_next = 1'b0;
                    free_next  = 1'b0;
                    state_next = pacl_pkg::S_SCAN;
                end
            end

            pacl_pkg::S_SCAN:
            begin
                // read data belongs to idx_reg; prefetch the next slot
                rd_en   = (idx_reg != LAST_IDX);
                rd_addr = idx_reg + 1'b1;
                if (hit)
                begin
                    match_next = 1'b1;
                    slot_next  = idx_reg;
                    count_next = rd_count;
                    state_next = pacl_pkg::S_RESOLVE;
                end
                else
                begin
                    if (!rd_valid && !free_reg)
                    begin
                        free_next = 1'b1;
                        slot_next = idx_reg;
                    end
                    if (idx_reg == LAST_IDX)
                        state_next = pacl_pkg::S_RESOLVE;
                    else
                        idx_next = idx_reg + 1'b1;
                end
            end

            pacl_pkg::S_RESOLVE:
            begin
                done_next    = 1'b1;
                allowed_next = 1'b0;
                status_next  = pacl_pkg::ST_OK;
                live_next    = '0;
                wr_addr      = slot_reg;
                state_next   = pacl_pkg::S_IDLE;
                if (req_reg == pacl_pkg::REQ_CONNECT)
                begin
                    if (match_reg)
                    begin
                        if ((count_cmp < max_cmp) && (count_reg != {COUNT_BITS{1'b1}}))
                        begin
                            new_count    = count_reg + 1'b1;
                            wr_en        = 1'b1;
                            wr_valid     = 1'b1;
                            wr_count     = new_count;
                            allowed_next = 1'b1;
                        end
                        else
                        begin
                            status_next = pacl_pkg::ST_OVER_LIMIT;
                        end
                        live_next = pacl_pkg::LIVE_BITS'(CMP_BITS'(new_count));
                    end
                    else if (max_per_address == '0)
                    begin
                        status_next = pacl_pkg::ST_OVER_LIMIT;
                    end
                    else if (free_reg)
                    begin
                        // insert the new address with one connection
                        wr_en        = 1'b1;
                        wr_valid     = 1'b1;
                        wr_count     = COUNT_BITS'(1);
                        allowed_next = 1'b1;
                        live_next    = pacl_pkg::LIVE_BITS'(1);
                    end
                    else
                    begin
                        status_next = pacl_pkg::ST_TABLE_FULL;
                    end
                end
                else
                begin
                    if (match_reg)
                    begin
                        if (count_reg != '0)
                            new_count = count_reg - 1'b1;
                        // free the slot when the last connection goes
                        wr_en        = 1'b1;
                        wr_valid     = (new_count != '0);
                        wr_count     = new_count;
                        allowed_next = 1'b1;
                        live_next    = pacl_pkg::LIVE_BITS'(CMP_BITS'(new_count));
                    end
                    else
                    begin
                        status_next = pacl_pkg::ST_UNKNOWN;
                    end
                end
            end

            default:
            begin
                state_next = pacl_pkg::S_CLEAR;
            end
        endcase
    end

    assign busy       = (state_reg != pacl_pkg::S_IDLE);
    assign done       = done_reg;
    assign allowed    = allowed_reg;
    assign status     = status_reg;
    assign live_count = live_reg;

`ifndef NO_ASSERTIONS
    a_done_after_resolve: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(state_reg == pacl_pkg::S_RESOLVE))
        else $error("result strobe without a resolve cycle");

    a_write_only_clear_or_resolve: assert property (@(posedge clk) disable iff (!rst_n)
        wr_en |-> (state_reg == pacl_pkg::S_CLEAR || state_reg == pacl_pkg::S_RESOLVE))
        else $error("table write outside clear or resolve");

    a_allowed_is_ok: assert property (@(posedge clk) disable iff (!rst_n)
        (done && allowed) |-> (status == pacl_pkg::ST_OK))
        else $error("admitted beat with a failure status");

    a_no_read_write_overlap: assert property (@(posedge clk) disable iff (!rst_n)
        wr_en |-> !rd_en)
        else $error("table read and write in the same cycle");
`endif

endmodule
